// File: hw/rtl/ohl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohl_pkg
// shared types and codes for the one-hot lut xor evaluator
// ----------------------------------------------------------------------------
package ohl_pkg;

    // item kinds carried on s_axis_tuser
    typedef enum logic [1:0] {
        KIND_LUT  = 2'd0,
        KIND_SEL  = 2'd1,
        KIND_EVAL = 2'd2
    } t_kind;

    // configuration register indexes
    localparam logic CFG_ACTIVE_IN_BITS = 1'b0;
    localparam logic CFG_OUT_BITS       = 1'b1;

    localparam int SEL_WORD_BITS = 64;
    localparam int BIT_POS_W     = 6;

    // input word layout
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // sequencer to accumulator control
    typedef struct packed {
        logic                 start;
        logic                 fold;
        logic [BIT_POS_W-1:0] bit_pos;
        logic                 emit;
    } t_acc_ctl;

endpackage

// File: hw/rtl/ohl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohl_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module ohl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/ohl_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohl_seq
// evaluate sequencer: walks the table entries and forms the read addresses
// ----------------------------------------------------------------------------
module ohl_seq
    import ohl_pkg::*;
#(
    parameter int IN_BITS = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_accept,
    input  logic [1:0]                                i_kind,
    input  logic [7:0]                                i_rot,
    input  logic [3:0]                                i_active_in_bits,
    input  logic                                      i_slot_free,
    output logic                                      o_ready,
    output t_acc_ctl                                  o_ctl,
    output logic [IN_BITS-1:0]                        o_lut_raddr,
    output logic [((IN_BITS > 6) ? IN_BITS - 6 : 1)-1:0] o_sel_raddr
);

    localparam int VA = (IN_BITS > 6) ? IN_BITS - 6 : 1;
    localparam int PW = VA + BIT_POS_W;

    t_state                 r_state, n_state;
    logic [IN_BITS-1:0]     r_i, n_i;
    logic [IN_BITS-1:0]     r_rot, n_rot;
    logic                   r_pend;
    logic [BIT_POS_W-1:0]   r_bit_pos;
    logic [4:0]             n_eff;
    logic [IN_BITS-1:0]     sel_mask;
    logic [IN_BITS-1:0]     rot_bit;
    logic [PW-1:0]          rot_pad;
    logic                   start;

    // entry count is 2^n with n clamped to 1..IN_BITS
    always_comb begin
        n_eff = (i_active_in_bits == 4'd0) ? 5'd1 : {1'b0, i_active_in_bits};
        for (int k = 0; k < IN_BITS; k++) begin
            sel_mask[k] = (5'(k) < n_eff);
        end
    end

    assign rot_bit     = (r_i ^ r_rot) & sel_mask;
    assign rot_pad     = PW'(rot_bit);
    assign o_lut_raddr = r_i;
    assign o_sel_raddr = rot_pad[PW-1:BIT_POS_W];
    assign start       = i_accept && (i_kind == KIND_EVAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == ST_RUN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_rot     <= n_rot;
        r_bit_pos <= rot_pad[BIT_POS_W-1:0];
    end

    always_comb begin
        n_state       = r_state;
        n_i           = r_i;
        n_rot         = r_rot;
        o_ready       = 1'b0;
        o_ctl.start   = start;
        o_ctl.fold    = r_pend;
        o_ctl.bit_pos = r_bit_pos;
        o_ctl.emit    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (start) begin
                    n_i     = '0;
                    n_rot   = IN_BITS'(i_rot);
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_i = r_i + 1'b1;
                if (r_i == sel_mask) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last read folds in this cycle
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_slot_free) begin
                    o_ctl.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/ohl_acc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohl_acc
// xor accumulator, output width mask and result register
// ----------------------------------------------------------------------------
module ohl_acc
    import ohl_pkg::*;
#(
    parameter int OUT_BITS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_acc_ctl                 i_ctl,
    input  logic [OUT_BITS-1:0]      i_init,
    input  logic [OUT_BITS-1:0]      i_lut_rdata,
    input  logic [SEL_WORD_BITS-1:0] i_sel_rdata,
    input  logic [6:0]               i_out_bits,
    input  logic                     i_tready,
    output logic                     o_slot_free,
    output logic                     o_tvalid,
    output logic [OUT_BITS-1:0]      o_result
);

    logic [OUT_BITS-1:0] r_acc;
    logic [OUT_BITS-1:0] r_result;
    logic                r_valid;
    logic [OUT_BITS-1:0] out_mask;

    // widths above OUT_BITS saturate since k never reaches them
    always_comb begin
        for (int k = 0; k < OUT_BITS; k++) begin
            out_mask[k] = (7'(k) < i_out_bits);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_acc <= i_init;
        end else if (i_ctl.fold && i_sel_rdata[i_ctl.bit_pos]) begin
            r_acc <= r_acc ^ i_lut_rdata;
        end
        if (i_ctl.emit) begin
            r_result <= r_acc & out_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_slot_free = !r_valid || i_tready;
    assign o_tvalid    = r_valid;
    assign o_result    = r_result;

endmodule

// File: hw/rtl/one_hot_lut_xor_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_hot_lut_xor_eval
// truth-table evaluator over a selector bit vector, xor of selected entries
// ----------------------------------------------------------------------------
// input stream s_axis: tuser is the kind (load table entry, load selector
// word, evaluate), tdata carries index, data and rot. a load word is written
// to its ram at the edge that takes it; it gives no result. an evaluate
// word walks all 2^n table entries (n from active_in_bits), one entry per
// cycle from the table ram and the selector ram, and the result then lands
// in the output register. one word is worked at a time; s_axis_tready is
// high only while the sequencer is idle.
// output stream m_axis: one result word per evaluate, held in a register.
// loads are still taken while a result waits; when the receiver stalls, an
// evaluate that finishes waits for the register to drain before ready rises.
// configuration writes must be made while idle; the block does not enforce it.
// reset clears the sequencer, the output valid and sets the registers to
// their defaults; table and selector contents are undefined until written.
// ----------------------------------------------------------------------------
module one_hot_lut_xor_eval
    import ohl_pkg::*;
#(
    parameter int IN_BITS  = 8,
    parameter int OUT_BITS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_addr,
    input  logic [6:0]             i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // index[7:0], data[71:8], rot[79:72]
    input  logic [1:0]             s_axis_tuser,   // kind[1:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // result[63:0]
);

    localparam int VA = (IN_BITS > 6) ? IN_BITS - 6 : 1;

    logic [3:0]               r_active_in_bits;
    logic [6:0]               r_out_bits;
    logic [7:0]               in_index;
    logic [63:0]              in_data;
    logic [7:0]               in_rot;
    logic                     accept;
    logic                     lut_we;
    logic                     sel_we;
    logic [IN_BITS-1:0]       lut_waddr;
    logic [VA-1:0]            sel_waddr;
    logic [IN_BITS-1:0]       lut_raddr;
    logic [VA-1:0]            sel_raddr;
    logic [OUT_BITS-1:0]      lut_rdata;
    logic [SEL_WORD_BITS-1:0] sel_rdata;
    logic                     slot_free;
    logic [OUT_BITS-1:0]      result;
    t_acc_ctl                 acc_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_in_bits <= 4'd8;
            r_out_bits       <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ACTIVE_IN_BITS: r_active_in_bits <= i_cfg_wdata[3:0];
                CFG_OUT_BITS:       r_out_bits       <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign in_index = s_axis_tdata[7:0];
    assign in_data  = s_axis_tdata[71:8];
    assign in_rot   = s_axis_tdata[79:72];
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign lut_we   = accept && (s_axis_tuser == KIND_LUT);
    assign sel_we   = accept && (s_axis_tuser == KIND_SEL);

    // write indexes wrap to the size of each store
    assign lut_waddr = IN_BITS'(in_index);
    assign sel_waddr = (IN_BITS > 6) ? VA'(in_index) : '0;

    ohl_ram #(
        .WIDTH (OUT_BITS),
        .DEPTH (1 << IN_BITS)
    ) u_lut_ram (
        .i_clk   (i_clk),
        .i_we    (lut_we),
        .i_waddr (lut_waddr),
        .i_wdata (in_data[OUT_BITS-1:0]),
        .i_raddr (lut_raddr),
        .o_rdata (lut_rdata)
    );

    ohl_ram #(
        .WIDTH (SEL_WORD_BITS),
        .DEPTH (1 << VA)
    ) u_sel_ram (
        .i_clk   (i_clk),
        .i_we    (sel_we),
        .i_waddr (sel_waddr),
        .i_wdata (in_data),
        .i_raddr (sel_raddr),
        .o_rdata (sel_rdata)
    );

    ohl_seq #(
        .IN_BITS (IN_BITS)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_kind           (s_axis_tuser),
        .i_rot            (in_rot),
        .i_active_in_bits (r_active_in_bits),
        .i_slot_free      (slot_free),
        .o_ready          (s_axis_tready),
        .o_ctl            (acc_ctl),
        .o_lut_raddr      (lut_raddr),
        .o_sel_raddr      (sel_raddr)
    );

    ohl_acc #(
        .OUT_BITS (OUT_BITS)
    ) u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (acc_ctl),
        .i_init      (in_data[OUT_BITS-1:0]),
        .i_lut_rdata (lut_rdata),
        .i_sel_rdata (sel_rdata),
        .i_out_bits  (r_out_bits),
        .i_tready    (m_axis_tready),
        .o_slot_free (slot_free),
        .o_tvalid    (m_axis_tvalid),
        .o_result    (result)
    );

    assign m_axis_tdata = OUT_TDATA_W'(result);

endmodule

// File: hw/rtl/ohl_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohl_check
// port-level checks for the one-hot lut xor evaluator
// ----------------------------------------------------------------------------
module ohl_check
    import ohl_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [1:0]             s_axis_tuser,   // kind[1:0]
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata    // result[63:0]
);

    logic s_accept;

    assign s_accept = s_axis_tvalid && s_axis_tready;

    // reset empties the result register
    a_rst_no_word: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // loads and unknown kinds leave the block ready
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && (s_axis_tuser != KIND_EVAL) |=> s_axis_tready)
        else $error("ready dropped after a load word");

    // an evaluate occupies the block
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && (s_axis_tuser == KIND_EVAL) |=> !s_axis_tready)
        else $error("ready held after an evaluate word");

    // a new result only comes out of a busy block
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while idle");

endmodule

bind one_hot_lut_xor_eval ohl_check u_ohl_check (.*);

// File: tb/sv/one_hot_lut_xor_eval_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_hot_lut_xor_eval_tb
// self-checking bench for the one-hot lut xor evaluator
// ----------------------------------------------------------------------------
// loads table entries and selector words, then evaluates under a series of
// input-size and output-width settings, from a short directed opening into
// long random runs. a class keeps its own copy of table, selector and
// registers and predicts each evaluate result; every result word taken on
// m_axis is compared with the oldest prediction. the sender works in bursts,
// the receiver stalls on its own pattern and once holds off long enough to
// back the block up. an evaluate is only sent once every entry it can touch
// has been loaded.
// ----------------------------------------------------------------------------
module one_hot_lut_xor_eval_tb;
    import ohl_pkg::*;

    localparam int          TABLE_BITS   = 8;
    localparam int          TABLE_DEPTH  = 1 << TABLE_BITS;
    localparam int          SEL_WORDS    = 4;
    localparam logic [1:0]  KIND_NONE    = 2'd3;
    localparam int          SETTLE_WAIT  = 300;
    localparam int          HOLD_CYCLES  = 1200;
    localparam int          STALL_LIMIT  = 20000;
    localparam int          NUM_PHASES   = 10;

    class lut_xor_checker;
        logic [63:0] lut_words [TABLE_DEPTH];
        logic [63:0] sel_words [SEL_WORDS];
        logic [3:0]  in_bits_reg;
        logic [6:0]  out_bits_reg;
        logic [63:0] expected_results [$];
        int          mismatches;

        function new();
            in_bits_reg  = 4'd8;
            out_bits_reg = 7'd64;
            mismatches   = 0;
            foreach (lut_words[i]) lut_words[i] = '0;
            foreach (sel_words[i]) sel_words[i] = '0;
        endfunction

        function void write_reg(logic addr, logic [6:0] value);
            if (addr == CFG_ACTIVE_IN_BITS) begin
                in_bits_reg = value[3:0];
            end else begin
                out_bits_reg = value;
            end
        endfunction

        // n as the block uses it: 0 counts as 1, large values saturate
        function int effective_in_bits();
            if (in_bits_reg == 4'd0) return 1;
            if (in_bits_reg > TABLE_BITS) return TABLE_BITS;
            return int'(in_bits_reg);
        endfunction

        function logic [63:0] fold_selected(logic [63:0] acc, logic [7:0] rot);
            int         count;
            int         m;
            logic [7:0] sel_mask;
            logic [7:0] entry;
            logic [7:0] pos;
            count    = 1 << effective_in_bits();
            sel_mask = 8'(count - 1);
            for (int i = 0; i < count; i++) begin
                entry = 8'(i);
                pos   = (entry ^ rot) & sel_mask;
                if (sel_words[pos[7:6]][pos[5:0]]) acc ^= lut_words[entry];
            end
            m = (out_bits_reg > 7'd64) ? 64 : int'(out_bits_reg);
            if (m == 0) return '0;
            if (m < 64) acc &= (64'd1 << m) - 64'd1;
            return acc;
        endfunction

        function void note_item(logic [1:0] kind, logic [7:0] index, logic [63:0] data,
                                logic [7:0] rot);
            if (kind == KIND_LUT) begin
                lut_words[index] = data;
            end else if (kind == KIND_SEL) begin
                sel_words[index[1:0]] = data;
            end else if (kind == KIND_EVAL) begin
                expected_results.push_back(fold_selected(data, rot));
            end
        endfunction

        function void check_result(logic [63:0] result);
            logic [63:0] want;
            if (expected_results.size() == 0) begin
                $error("unexpected result word %h", result);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (result !== want) begin
                $error("field result: expected %h actual %h", want, result);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [6:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;    // index[7:0], data[71:8], rot[79:72]
    logic [1:0]  s_axis_tuser;    // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;    // result[63:0]

    lut_xor_checker board = new();

    bit lut_loaded [TABLE_DEPTH];
    bit sel_loaded [SEL_WORDS];
    int burst_left;
    bit hold_request;

    // per phase: active_in_bits, out_bits, number of random words
    int phase_in_bits  [NUM_PHASES] = '{3, 8, 2, 15, 1, 5, 0, 4, 6, 7};
    int phase_out_bits [NUM_PHASES] = '{64, 64, 1, 127, 33, 63, 0, 64, 17, 48};
    int phase_words    [NUM_PHASES] = '{84, 78, 70, 70, 63, 84, 42, 84, 78, 84};

    one_hot_lut_xor_eval u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    task automatic cfg_write(logic addr, logic [6:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        board.write_reg(addr, value);
    endtask

    task automatic idle_input(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    // offer one word and hold it until the block takes it
    task automatic push_word(logic [1:0] kind, logic [7:0] index, logic [63:0] data,
                             logic [7:0] rot);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {rot, data, index};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_item(kind, index, data, rot);
        if (kind == KIND_LUT) lut_loaded[index] = 1'b1;
        if (kind == KIND_SEL) sel_loaded[index[1:0]] = 1'b1;
    endtask

    // bursts of random length with random gaps between them
    task automatic paced_push(logic [1:0] kind, logic [7:0] index, logic [63:0] data,
                              logic [7:0] rot);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 12));
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        push_word(kind, index, data, rot);
    endtask

    // load whatever an evaluate at the current n could read but was never written
    task automatic fill_for_eval();
        int count;
        count = 1 << board.effective_in_bits();
        for (int i = 0; i < count; i++) begin
            if (!lut_loaded[i]) paced_push(KIND_LUT, 8'(i), rand_word(), 8'($urandom()));
        end
        for (int w = 0; w <= (count - 1) >> 6; w++) begin
            if (!sel_loaded[w]) begin
                paced_push(KIND_SEL, 8'(w + 4 * $urandom_range(0, 63)), rand_word(),
                           8'($urandom()));
            end
        end
    endtask

    task automatic settle();
        idle_input(1);
        while (board.expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic random_phase(int words);
        int pick;
        int done;
        done = 0;
        while (done < words) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // ignored by the block, not counted
                paced_push(KIND_NONE, 8'($urandom()), rand_word(), 8'($urandom()));
            end else if (pick < 38) begin
                paced_push(KIND_LUT, 8'($urandom()), rand_word(), 8'($urandom()));
                done++;
            end else if (pick < 50) begin
                paced_push(KIND_SEL, 8'($urandom()), rand_word(), 8'($urandom()));
                done++;
            end else begin
                fill_for_eval();
                paced_push(KIND_EVAL, 8'($urandom()), rand_word(), 8'($urandom()));
                done++;
            end
        end
    endtask

    // receiver: stall pattern of its own plus one long hold-off on request
    initial begin
        int mode;
        int mode_left;
        int run_left;
        int hold_left;
        m_axis_tready = 1'b0;
        mode_left = 0;
        run_left  = 0;
        hold_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (mode == 0) begin
                m_axis_tready <= 1'b1;
            end else if (mode == 1) begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end else begin
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 15);
                    m_axis_tready <= ~m_axis_tready;
                end
                run_left--;
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
        end
    end

    // watchdog on cycles with no word moving on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        burst_left    = 0;
        hold_request  = 1'b0;
        foreach (lut_loaded[i]) lut_loaded[i] = 1'b0;
        foreach (sel_loaded[i]) sel_loaded[i] = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: two-entry table, extremes of every field
        cfg_write(CFG_ACTIVE_IN_BITS, 7'd1);
        cfg_write(CFG_OUT_BITS, 7'd64);
        push_word(KIND_LUT, 8'd0, '1, 8'd0);
        push_word(KIND_LUT, 8'd1, 64'h8000_0000_0000_0001, 8'hff);
        push_word(KIND_SEL, 8'd0, 64'h1, 8'd0);
        push_word(KIND_EVAL, 8'd0, '0, 8'd0);
        push_word(KIND_EVAL, 8'd0, '1, 8'hff);     // rotation flips which entry is taken
        push_word(KIND_SEL, 8'hff, '1, 8'd0);      // index wraps to the last word
        push_word(KIND_SEL, 8'd0, '1, 8'd0);
        push_word(KIND_EVAL, 8'hff, 64'h0123_4567_89ab_cdef, 8'h5a);
        push_word(KIND_NONE, 8'hff, '1, 8'hff);
        push_word(KIND_SEL, 8'd0, '0, 8'd0);
        push_word(KIND_EVAL, 8'd0, 64'hdead_beef_cafe_f00d, 8'd1);
        push_word(KIND_LUT, 8'hff, '0, 8'd0);
        push_word(KIND_SEL, 8'd0, 64'h2, 8'd0);
        settle();
        // n of zero behaves as one, zero output width, oversize output width
        cfg_write(CFG_ACTIVE_IN_BITS, 7'd0);
        cfg_write(CFG_OUT_BITS, 7'd0);
        push_word(KIND_EVAL, 8'd0, '1, 8'd0);
        settle();
        cfg_write(CFG_OUT_BITS, 7'd1);
        push_word(KIND_EVAL, 8'd0, '1, 8'd1);
        push_word(KIND_EVAL, 8'd0, 64'hffff_ffff_ffff_fffe, 8'd0);
        settle();
        cfg_write(CFG_OUT_BITS, 7'd127);
        push_word(KIND_EVAL, 8'd0, 64'h5555_aaaa_5555_aaaa, 8'd0);
        push_word(KIND_EVAL, 8'd0, 64'h5555_aaaa_5555_aaaa, 8'd255);
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            cfg_write(CFG_ACTIVE_IN_BITS, 7'(phase_in_bits[p]));
            cfg_write(CFG_OUT_BITS, 7'(phase_out_bits[p]));
            if (p == 0) hold_request = 1'b1;
            random_phase(phase_words[p]);
            settle();
        end

        if (board.expected_results.size() != 0) begin
            $error("%0d result words never arrived", board.expected_results.size());
            board.mismatches++;
        end
        if (board.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
